>>> rtl/assert_macros.svh
// Assertion macros shared by the noise pipeline modules.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/vnf_pkg.sv
// Shared constants and types for the fractal value noise pipeline.
// Depends on nothing.
package vnf_pkg;
	localparam int OctaveCount = 5;
	localparam int ColW = 32;
	localparam int FracW = 16;
	localparam int ValW = 17;
	localparam int HeightW = 17;
	localparam int AccW = ValW + OctaveCount;
	localparam int PipeDepth = 11;
	localparam logic [31:0] HashRowMul = 32'd57;
	localparam int HashShift = 13;
	localparam logic [31:0] HashC1 = 32'd15731;
	localparam logic [31:0] HashC2 = 32'd789221;
	localparam logic [31:0] HashC3 = 32'd1376312589;
	localparam logic [ValW-1:0] OneQ16 = 17'd65536;

	typedef logic [ColW-1:0] lat_t;
	typedef logic [FracW-1:0] frac_t;
	typedef logic [ValW-1:0] val_t;
	typedef logic [AccW-1:0] acc_t;
endpackage

>>> rtl/value_noise_fbm_2d.sv
// Fractal value noise over a 2D lattice: top level with handshake control.
// Depends on vnf_pkg, vnf_octave and assert_macros.svh.
//
// Usage: present coord_x and coord_y (signed Q16.16) with valid; a beat is
// taken when valid and ready are both high. Each beat yields exactly one
// height (unsigned Q1.16) on the output channel, in order.
// All octaves run side by side in a pipeline of eleven register stages:
// nine inside each octave unit, one for the weighted sum and one output
// register. The valid bit of a beat moves with it through every stage, and
// unless the receiver stalls, the block sustains one beat per cycle.
// The whole pipeline advances only when its last stage is empty or is
// being taken, so a stalled receiver freezes every stage in place and
// ready falls; nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
`include "assert_macros.svh"
module value_noise_fbm_2d (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [vnf_pkg::ColW-1:0]  coord_x,
	input  logic signed [vnf_pkg::ColW-1:0]  coord_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [vnf_pkg::HeightW-1:0]     height
);
	import vnf_pkg::*;

	logic [PipeDepth-1:0] vld_q;
	logic             adv;
	val_t             oct_val [OctaveCount];
	acc_t             sum_c;
	acc_t             sum_s10;
	logic [HeightW-1:0] height_s11;

	assign adv       = !vld_q[PipeDepth-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[PipeDepth-1];
	assign height    = height_s11;

	for (genvar i = 0; i < OctaveCount; i++) begin : g_oct
		logic [ColW+FracW+OctaveCount-1:0] sx, sy;
		assign sx = {{(OctaveCount+FracW){coord_x[ColW-1]}}, coord_x} << i;
		assign sy = {{(OctaveCount+FracW){coord_y[ColW-1]}}, coord_y} << i;
		vnf_octave u_oct (
			.clk, .arst_n, .en(adv),
			.lx(sx[FracW+ColW-1:FracW]), .ly(sy[FracW+ColW-1:FracW]),
			.fx(sx[FracW-1:0]), .fy(sy[FracW-1:0]),
			.value(oct_val[i])
		);
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < OctaveCount; i++) begin
			sum_c = sum_c + (acc_t'(oct_val[i]) << (OctaveCount - 1 - i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PipeDepth-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s10    <= sum_c;
			height_s11 <= HeightW'(sum_s10 >> (OctaveCount - 1));
		end
	end

	`ASSERT_IMPL(a_stall_ready, clk, arst_n, out_valid && !out_ready, !in_ready)
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(height))
	`ASSERT_IMPL(a_range, clk, arst_n, out_valid, height <= 17'd127008)
endmodule

>>> rtl/vnf_hash.sv
// Pipelined lattice hash: corner index pair to unsigned Q1.16 corner value in five stages.
// Depends on vnf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vnf_hash (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  vnf_pkg::lat_t lx,
	input  vnf_pkg::lat_t ly,
	output vnf_pkg::val_t value
);
	import vnf_pkg::*;

	logic [31:0] n_s1, nn_s2, n_s2, inner_s3, n_s3, m_s4;
	logic [31:0] n0;
	val_t        value_s5;

	always_comb begin
		n0 = lx + ly * HashRowMul;
	end

	// The second, third and fourth stages each hold one 32-bit wrapping multiply.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1     <= (n0 << HashShift) ^ n0;
			nn_s2    <= n_s1 * n_s1;
			n_s2     <= n_s1;
			inner_s3 <= nn_s2 * HashC1 + HashC2;
			n_s3     <= n_s2;
			m_s4     <= n_s3 * inner_s3 + HashC3;
			value_s5 <= OneQ16 - val_t'(m_s4[30:15]);
		end
	end

	assign value = value_s5;

	`ASSERT_IMPL(a_value_range, clk, arst_n, 1'b1, value_s5 <= OneQ16)
endmodule

>>> rtl/vnf_octave.sv
// One octave: smoothstep weights, four corner hashes and the bilinear blend.
// Depends on vnf_pkg and vnf_hash; the registers advance only when enabled.
module vnf_octave (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  vnf_pkg::lat_t  lx,
	input  vnf_pkg::lat_t  ly,
	input  vnf_pkg::frac_t fx,
	input  vnf_pkg::frac_t fy,
	output vnf_pkg::val_t  value
);
	import vnf_pkg::*;

	val_t h00, h10, h01, h11;
	logic [31:0] tx2_s1, ty2_s1;
	logic [17:0] kx_s1, ky_s1;
	logic [49:0] uxp_s2, vyp_s2;
	frac_t u_s3, v_s3, u_s4, v_s4, u_s5, v_s5, v_s6, v_s7;
	logic [33:0] r0a_s6, r0b_s6, r1a_s6, r1b_s6;
	val_t r0_s7, r1_s7;
	logic [33:0] ba_s8, bb_s8;
	val_t out_s9;

	vnf_hash u_h00 (.clk, .arst_n, .en, .lx(lx), .ly(ly), .value(h00));
	vnf_hash u_h10 (.clk, .arst_n, .en, .lx(lx + lat_t'(1)), .ly(ly), .value(h10));
	vnf_hash u_h01 (.clk, .arst_n, .en, .lx(lx), .ly(ly + lat_t'(1)), .value(h01));
	vnf_hash u_h11 (.clk, .arst_n, .en, .lx(lx + lat_t'(1)), .ly(ly + lat_t'(1)),
		.value(h11));

	// The weights are ready after three stages and wait two more for the hashes.
	always_ff @(posedge clk) begin
		if (en) begin
			tx2_s1 <= fx * fx;
			ty2_s1 <= fy * fy;
			kx_s1  <= 18'd196608 - {1'b0, fx, 1'b0};
			ky_s1  <= 18'd196608 - {1'b0, fy, 1'b0};
			uxp_s2 <= tx2_s1 * kx_s1;
			vyp_s2 <= ty2_s1 * ky_s1;
			u_s3   <= uxp_s2[47:32];
			v_s3   <= vyp_s2[47:32];
			u_s4   <= u_s3;
			v_s4   <= v_s3;
			u_s5   <= u_s4;
			v_s5   <= v_s4;
			r0a_s6 <= h00 * (OneQ16 - val_t'(u_s5));
			r0b_s6 <= h10 * val_t'(u_s5);
			r1a_s6 <= h01 * (OneQ16 - val_t'(u_s5));
			r1b_s6 <= h11 * val_t'(u_s5);
			v_s6   <= v_s5;
			r0_s7  <= val_t'((r0a_s6 + r0b_s6) >> 16);
			r1_s7  <= val_t'((r1a_s6 + r1b_s6) >> 16);
			v_s7   <= v_s6;
			ba_s8  <= r0_s7 * (OneQ16 - val_t'(v_s7));
			bb_s8  <= r1_s7 * val_t'(v_s7);
			out_s9 <= val_t'((ba_s8 + bb_s8) >> 16);
		end
	end

	assign value = out_s9;
endmodule
